// ===== hw/rtl/stereo_comb_allpass_reverb_macros.svh =====
// assertion helpers for the reverb block
`ifndef STEREO_COMB_ALLPASS_REVERB_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_MACROS_SVH

// checked while out of reset
`define SCAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SCAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/scar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_pkg
// Types, constants and fixed-point helpers of the stereo reverb.
// ----------------------------------------------------------------------------
package scar_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned SPREAD      = 23;

  // comb and allpass base lengths at the reference rate
  localparam int unsigned COMB_BASE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
  localparam int unsigned AP_BASE   [4] = '{556, 441, 341, 225};

  localparam int unsigned GAIN_Q16      = 983;
  localparam int unsigned FB_BASE_Q16   = 45875;
  localparam int unsigned FB_SPAN_Q16   = 18350;
  localparam int unsigned DAMP_SPAN_Q16 = 26214;

  // register indexes
  localparam logic [1:0] REG_ROOM    = 2'd0;
  localparam logic [1:0] REG_DAMPING = 2'd1;
  localparam logic [1:0] REG_WIDTH   = 2'd2;
  localparam logic [1:0] REG_QUALITY = 2'd3;

  localparam logic [1:0] QUAL_LOW = 2'd0;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] send_sample;
    logic                          block_end;
  } scar_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] wet_left;
    logic signed [SAMPLE_BITS-1:0] wet_right;
    logic                          block_end_out;
  } scar_out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_GAIN, S_GAINR,
    S_CRD, S_CM1, S_CM2, S_CLP, S_CM3, S_CWR,
    S_ARD, S_AWR,
    S_OM1, S_OM2, S_OM3, S_OM4, S_OM5, S_DONE
  } scar_state_t;

  typedef logic signed [51:0] wide_t;

  localparam wide_t S32_MAX = 52'sd2147483647;
  localparam wide_t S32_MIN = -52'sd2147483648;
  localparam wide_t SOUT_MAX = 52'sd8388607;
  localparam wide_t SOUT_MIN = -52'sd8388608;

  // round half up then arithmetic shift
  function automatic wide_t rnd_shr(input wide_t v, input int unsigned s);
    wide_t half;
    half = wide_t'(52'sd1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input wide_t v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SOUT_MAX) r = SOUT_MAX[SAMPLE_BITS-1:0];
    else if (v < SOUT_MIN) r = SOUT_MIN[SAMPLE_BITS-1:0];
    else r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/scar_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scar_ram
// Single-port synchronous delay-line memory with registered read data.
// ----------------------------------------------------------------------------
module scar_ram import scar_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      addr,
  input  logic signed [31:0] wdata,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  // write and registered read at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/stereo_comb_allpass_reverb.sv =====
`timescale 1ns / 1ps
// One sample at a time: in_stall is high from the accepted sample until its
// result is loaded into the output register; one shared multiplier, and one read
// and one write of a delay memory per comb and allpass step.
// Reset: synchronous, active low; after reset a clearing pass of one word a
// cycle over the comb and allpass memories (sized for SAMPLE_RATE, default
// 44.1 kHz) runs before input; configuration writes are taken during it.
`include "stereo_comb_allpass_reverb_macros.svh"
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// Stereo comb/allpass reverb, delay lines held in two synchronous memories.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb import scar_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = 44100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  scar_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output scar_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // delay lengths scaled to the sample rate
  function automatic int unsigned slen(input int unsigned b);
    int unsigned s;
    s = (b * SAMPLE_RATE) / 44100;
    return (s > 0) ? s : 1;
  endfunction

  function automatic int unsigned comb_len(input int unsigned k);
    return slen(COMB_BASE[k & 7] + ((k >= 8) ? SPREAD : 0));
  endfunction

  function automatic int unsigned ap_len(input int unsigned k);
    return slen(AP_BASE[k & 3] + ((k >= 4) ? SPREAD : 0));
  endfunction

  function automatic int unsigned comb_base(input int unsigned k);
    int unsigned s;
    s = 0;
    for (int unsigned j = 0; j < k; j++) s += comb_len(j);
    return s;
  endfunction

  function automatic int unsigned ap_base(input int unsigned k);
    int unsigned s;
    s = 0;
    for (int unsigned j = 0; j < k; j++) s += ap_len(j);
    return s;
  endfunction

  localparam int unsigned CTOT = comb_base(16);
  localparam int unsigned ATOT = ap_base(8);
  localparam int unsigned CAW  = $clog2(CTOT);
  localparam int unsigned AAW  = $clog2(ATOT);
  localparam int unsigned CPW  = $clog2(comb_len(15)) > 0 ? $clog2(comb_len(15)) : 1;
  localparam int unsigned APW  = $clog2(ap_len(4)) > 0 ? $clog2(ap_len(4)) : 1;

  localparam int unsigned CLEN_T [16] = '{
    comb_len(0), comb_len(1), comb_len(2), comb_len(3),
    comb_len(4), comb_len(5), comb_len(6), comb_len(7),
    comb_len(8), comb_len(9), comb_len(10), comb_len(11),
    comb_len(12), comb_len(13), comb_len(14), comb_len(15)};
  localparam int unsigned CBASE_T [16] = '{
    comb_base(0), comb_base(1), comb_base(2), comb_base(3),
    comb_base(4), comb_base(5), comb_base(6), comb_base(7),
    comb_base(8), comb_base(9), comb_base(10), comb_base(11),
    comb_base(12), comb_base(13), comb_base(14), comb_base(15)};
  localparam int unsigned ALEN_T [8] = '{
    ap_len(0), ap_len(1), ap_len(2), ap_len(3),
    ap_len(4), ap_len(5), ap_len(6), ap_len(7)};
  localparam int unsigned ABASE_T [8] = '{
    ap_base(0), ap_base(1), ap_base(2), ap_base(3),
    ap_base(4), ap_base(5), ap_base(6), ap_base(7)};

  // configuration registers
  logic [15:0] room_r, damping_r, width_r;
  logic [1:0]  quality_r;
  logic [15:0] fb_r;
  logic [14:0] dmp_r;

  // control state
  scar_state_t        state_r, state_nxt;
  logic               ch_r;
  logic [2:0]         idx_r;
  logic [CAW-1:0]     clr_r;
  logic signed [31:0] lp_r [16];
  logic [CPW-1:0]     cpos_r [16];
  logic [APW-1:0]     apos_r [8];
  logic               out_valid_r;

  // payload registers
  scar_in_t           in_r;
  wide_t              prod_r, sum_r;
  logic signed [31:0] x_r, y_r, acc_r, bank0_r;
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;
  scar_out_t          out_r;

  logic [3:0]  ck;
  logic [2:0]  ak;
  logic        cfg_wr, accept, out_free, last_comb, last_ap;
  logic [31:0] fb_prod, dmp_prod;

  assign ck        = {ch_r, idx_r};
  assign ak        = {ch_r, idx_r[1:0]};
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_comb = (quality_r == QUAL_LOW) ? (idx_r == 3'd3) : (idx_r == 3'd7);
  assign last_ap   = (quality_r == QUAL_LOW) ? (idx_r == 3'd1) : (idx_r == 3'd3);

  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_ROOM:    prdata = 32'(room_r);
      REG_DAMPING: prdata = 32'(damping_r);
      REG_WIDTH:   prdata = 32'(width_r);
      REG_QUALITY: prdata = 32'(quality_r);
      default:     prdata = '0;
    endcase
  end

  // derived coefficients
  assign fb_prod  = 32'(room_r) * 32'(FB_SPAN_Q16);
  assign dmp_prod = 32'(damping_r) * 32'(DAMP_SPAN_Q16);

  // delay memories
  logic               c_we, a_we;
  logic [CAW-1:0]     c_addr;
  logic [AAW-1:0]     a_addr;
  logic signed [31:0] c_wdata, a_wdata, c_rdata, a_rdata;

  // shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  wide_t              prod;
  logic signed [17:0] wet1, wet2, one_minus_damp;

  assign wet1           = 18'sd65536 + signed'({2'b00, width_r});
  assign wet2           = 18'sd65536 - signed'({2'b00, width_r});
  assign one_minus_damp = 18'sd65536 - signed'({3'b000, dmp_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_GAIN: begin
        mul_a = 33'(in_r.send_sample);
        mul_b = 18'(GAIN_Q16);
      end
      S_CM1: begin
        mul_a = 33'(c_rdata);
        mul_b = one_minus_damp;
      end
      S_CM2: begin
        mul_a = 33'(lp_r[ck]);
        mul_b = signed'({3'b000, dmp_r});
      end
      S_CM3: begin
        mul_a = 33'(lp_r[ck]);
        mul_b = signed'({2'b00, fb_r});
      end
      S_OM1: begin
        mul_a = 33'(bank0_r);
        mul_b = wet1;
      end
      S_OM2: begin
        mul_a = 33'(acc_r);
        mul_b = wet2;
      end
      S_OM3: begin
        mul_a = 33'(acc_r);
        mul_b = wet1;
      end
      S_OM4: begin
        mul_a = 33'(bank0_r);
        mul_b = wet2;
      end
      default: ;
    endcase
  end

  assign prod = wide_t'(mul_a) * wide_t'(mul_b);

  always_comb begin
    c_we    = 1'b0;
    a_we    = 1'b0;
    c_addr  = CAW'(CBASE_T[ck]) + CAW'(cpos_r[ck]);
    a_addr  = AAW'(ABASE_T[ak]) + AAW'(apos_r[ak]);
    c_wdata = sat32(wide_t'(x_r) + rnd_shr(prod_r, 16));
    a_wdata = sat32(wide_t'(acc_r) + rnd_shr(wide_t'(a_rdata), 1));
    if (state_r == S_CLEAR) begin
      c_we    = 1'b1;
      a_we    = (clr_r < CAW'(ATOT));
      c_addr  = clr_r;
      a_addr  = clr_r[AAW-1:0];
      c_wdata = '0;
      a_wdata = '0;
    end else if (state_r == S_CWR) begin
      c_we = 1'b1;
    end else if (state_r == S_AWR) begin
      a_we = 1'b1;
    end
  end

  scar_ram #(.DEPTH(CTOT), .AW(CAW)) u_comb_ram (
    .clk   (clk),
    .we    (c_we),
    .addr  (c_addr),
    .wdata (c_wdata),
    .rdata (c_rdata)
  );

  scar_ram #(.DEPTH(ATOT), .AW(AAW)) u_ap_ram (
    .clk   (clk),
    .we    (a_we),
    .addr  (a_addr),
    .wdata (a_wdata),
    .rdata (a_rdata)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == CAW'(CTOT - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_GAINR;
      S_GAINR: state_nxt = S_CRD;
      S_CRD:   state_nxt = S_CM1;
      S_CM1:   state_nxt = S_CM2;
      S_CM2:   state_nxt = S_CLP;
      S_CLP:   state_nxt = S_CM3;
      S_CM3:   state_nxt = S_CWR;
      S_CWR:   state_nxt = last_comb ? S_ARD : S_CRD;
      S_ARD:   state_nxt = S_AWR;
      S_AWR: begin
        if (!last_ap) state_nxt = S_ARD;
        else if (ch_r) state_nxt = S_OM1;
        else state_nxt = S_CRD;
      end
      S_OM1:   state_nxt = S_OM2;
      S_OM2:   state_nxt = S_OM3;
      S_OM3:   state_nxt = S_OM4;
      S_OM4:   state_nxt = S_OM5;
      S_OM5:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ch_r        <= 1'b0;
      idx_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      room_r      <= 16'd32768;
      damping_r   <= 16'd32768;
      width_r     <= 16'd65535;
      quality_r   <= 2'd1;
      fb_r        <= '0;
      dmp_r       <= '0;
      for (int i = 0; i < 16; i++) begin
        lp_r[i]   <= '0;
        cpos_r[i] <= '0;
      end
      for (int i = 0; i < 8; i++) begin
        apos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fb_r    <= 16'(FB_BASE_Q16) + 16'((fb_prod + 32'd32768) >> 16);
      dmp_r   <= 15'((dmp_prod + 32'd32768) >> 16);

      // configuration writes
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ROOM:    room_r    <= pwdata[15:0];
          REG_DAMPING: damping_r <= pwdata[15:0];
          REG_WIDTH:   width_r   <= pwdata[15:0];
          REG_QUALITY: quality_r <= pwdata[1:0];
          default: ;
        endcase
      end

      // walk over combs and allpasses
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_GAINR: begin
          ch_r  <= 1'b0;
          idx_r <= '0;
        end
        S_CLP: lp_r[ck] <= sat32(rnd_shr(sum_r + prod_r, 16));
        S_CWR: begin
          cpos_r[ck] <= (cpos_r[ck] == CPW'(CLEN_T[ck] - 1)) ? '0 : cpos_r[ck] + 1'b1;
          idx_r      <= last_comb ? 3'd0 : idx_r + 3'd1;
        end
        S_AWR: begin
          apos_r[ak] <= (apos_r[ak] == APW'(ALEN_T[ak] - 1)) ? '0 : apos_r[ak] + 1'b1;
          idx_r      <= last_ap ? 3'd0 : idx_r + 3'd1;
          if (last_ap) ch_r <= !ch_r;
        end
        default: ;
      endcase

      // output register
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE:  if (accept) in_r <= in_data;
      S_GAIN:  prod_r <= prod;
      S_GAINR: begin
        x_r   <= sat32(rnd_shr(prod_r, 16));
        acc_r <= '0;
      end
      S_CM1: begin
        y_r    <= c_rdata;
        prod_r <= prod;
      end
      S_CM2: begin
        sum_r  <= prod_r;
        prod_r <= prod;
      end
      S_CM3:   prod_r <= prod;
      S_CWR:   acc_r <= sat32(wide_t'(acc_r) + wide_t'(y_r));
      S_AWR: begin
        if (last_ap && !ch_r) begin
          bank0_r <= sat32(wide_t'(a_rdata) - wide_t'(acc_r));
          acc_r   <= '0;
        end else begin
          acc_r <= sat32(wide_t'(a_rdata) - wide_t'(acc_r));
        end
      end
      S_OM1:   prod_r <= prod;
      S_OM2: begin
        sum_r  <= prod_r;
        prod_r <= prod;
      end
      S_OM3: begin
        left_r <= sat_out(rnd_shr(sum_r + prod_r, 17));
        prod_r <= prod;
      end
      S_OM4: begin
        sum_r  <= prod_r;
        prod_r <= prod;
      end
      S_OM5:   right_r <= sat_out(rnd_shr(sum_r + prod_r, 17));
      S_DONE: begin
        if (out_free) begin
          out_r.wet_left      <= left_r;
          out_r.wet_right     <= right_r;
          out_r.block_end_out <= in_r.block_end;
        end
      end
      default: ;
    endcase
  end

  // checks
  `SCAR_ASSERT_ALWAYS(a_no_input_in_clear, (state_r == S_CLEAR) |-> in_stall, "input during clear")
  `SCAR_ASSERT(a_accept_starts, accept |=> (state_r == S_GAIN), "accepted item not started")
  `SCAR_ASSERT(a_comb_we_state, c_we |-> (state_r == S_CWR || state_r == S_CLEAR), "stray comb write")
  `SCAR_ASSERT(a_result_loads, (state_r == S_DONE && out_free) |=> out_valid, "result not presented")

endmodule

// ===== bench/stereo_comb_allpass_reverb_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_tb
// Streams mono send samples through the reverb and compares every wet stereo
// transfer with a fixed-point comb/allpass predictor or a directed row's value.
// Several room, damping, width, quality settings; random input/output idling.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb_tb;
  import scar_pkg::*;

  localparam int COMB_DEPTH = 1617 + SPREAD;
  localparam int AP_DEPTH   = 556 + SPREAD;
  localparam int DRAIN      = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  scar_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  scar_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stereo_comb_allpass_reverb dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies held by the predictor
  logic [15:0] room_q = 16'd32768;
  logic [15:0] damp_q = 16'd32768;
  logic [15:0] width_q = 16'd65535;
  logic [1:0]  qual_q = 2'd1;

  // predictor state, cleared like the block at reset
  int comb_line [2][8][COMB_DEPTH];
  int ap_line   [2][4][AP_DEPTH];
  int comb_lp   [2][8];
  int comb_pos  [2][8];
  int ap_pos    [2][4];

  scar_out_t wet_expected [$];
  bit        failed = 1'b0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;

  // typed expectation travels with the transfer
  logic      row_has_exp = 1'b0;
  scar_out_t row_exp = '0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clip_out(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // one sample through both banks
  function automatic scar_out_t reverb_step(scar_in_t it);
    scar_out_t r;
    longint fb, dmp, w1, w2, send;
    int x, len, p, y, lp, b, ncomb, nap;
    int bank [2];
    fb = FB_BASE_Q16 + rnd_shift(longint'(room_q) * FB_SPAN_Q16, 16);
    dmp = rnd_shift(longint'(damp_q) * DAMP_SPAN_Q16, 16);
    w1 = 65536 + longint'(width_q);
    w2 = 65536 - longint'(width_q);
    send = longint'(it.send_sample);
    ncomb = (qual_q == QUAL_LOW) ? 4 : 8;
    nap = (qual_q == QUAL_LOW) ? 2 : 4;
    x = clip32(rnd_shift(send * GAIN_Q16, 16));
    for (int ch = 0; ch < 2; ch++) begin
      bank[ch] = 0;
      for (int c = 0; c < ncomb; c++) begin
        len = COMB_BASE[c] + ch * SPREAD;
        p = comb_pos[ch][c];
        y = comb_line[ch][c][p];
        lp = clip32(rnd_shift(longint'(y) * (65536 - dmp) + longint'(comb_lp[ch][c]) * dmp, 16));
        comb_lp[ch][c] = lp;
        comb_line[ch][c][p] = clip32(longint'(x) + rnd_shift(longint'(lp) * fb, 16));
        comb_pos[ch][c] = (p + 1 >= len) ? 0 : p + 1;
        bank[ch] = clip32(longint'(bank[ch]) + y);
      end
      for (int a = 0; a < nap; a++) begin
        len = AP_BASE[a] + ch * SPREAD;
        p = ap_pos[ch][a];
        b = ap_line[ch][a][p];
        ap_line[ch][a][p] = clip32(longint'(bank[ch]) + rnd_shift(longint'(b), 1));
        ap_pos[ch][a] = (p + 1 >= len) ? 0 : p + 1;
        bank[ch] = clip32(longint'(b) - longint'(bank[ch]));
      end
    end
    r.wet_left = clip_out(rnd_shift(longint'(bank[0]) * w1 + longint'(bank[1]) * w2, 17));
    r.wet_right = clip_out(rnd_shift(longint'(bank[1]) * w1 + longint'(bank[0]) * w2, 17));
    r.block_end_out = it.block_end;
    return r;
  endfunction

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // transfer monitor and scoreboard
  always @(posedge clk) begin
    scar_out_t pred, want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = reverb_step(in_data);
        wet_expected.push_back(row_has_exp ? row_exp : pred);
      end
      if (out_valid && !out_stall) begin
        if (wet_expected.size() == 0) begin
          $error("unexpected wet transfer %h", out_data);
          failed = 1'b1;
        end else begin
          want = wet_expected.pop_front();
          if (out_data.wet_left !== want.wet_left) begin
            $error("wet_left expected %0d got %0d", want.wet_left, out_data.wet_left);
            failed = 1'b1;
          end
          if (out_data.wet_right !== want.wet_right) begin
            $error("wet_right expected %0d got %0d", want.wet_right, out_data.wet_right);
            failed = 1'b1;
          end
          if (out_data.block_end_out !== want.block_end_out) begin
            $error("block_end_out expected %0b got %0b", want.block_end_out,
                   out_data.block_end_out);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // register write, setup then access, then the bus idles
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROOM:    room_q = val[15:0];
      REG_DAMPING: damp_q = val[15:0];
      REG_WIDTH:   width_q = val[15:0];
      default:     qual_q = val[1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] rs, logic [15:0] dm, logic [15:0] wd, logic [1:0] q);
    reg_write(REG_ROOM, 32'(rs));
    reg_write(REG_DAMPING, 32'(dm));
    reg_write(REG_WIDTH, 32'(wd));
    reg_write(REG_QUALITY, 32'(q));
  endtask

  // sender holds valid until the transfer
  task automatic send_sample(scar_in_t it, logic has_exp, scar_out_t exp_val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_has_exp <= has_exp;
    row_exp <= exp_val;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every wet sample has come back
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wet_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_run(int count);
    scar_in_t it;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0:       it.send_sample = 24'sh7fffff;
        1:       it.send_sample = 24'sh800000;
        default: it.send_sample = 24'($urandom);
      endcase
      it.block_end = ($urandom_range(0, 7) == 0);
      send_sample(it, 1'b0, '0);
    end
  endtask

  typedef struct {
    scar_in_t  stim;
    logic      has_exp;
    scar_out_t wet;
  } dir_row_t;

  // directed rows; the stores are all zero so early outputs are silence
  dir_row_t dir_rows [12] = '{
    '{'{24'sh7fffff, 1'b0}, 1'b1, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh800000, 1'b1}, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{'{24'sh000000, 1'b0}, 1'b1, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'shffffff, 1'b1}, 1'b1, '{24'sd0, 24'sd0, 1'b1}},
    '{'{24'sh000001, 1'b0}, 1'b1, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh555555, 1'b0}, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'shaaaaaa, 1'b1}, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh7fffff, 1'b0}, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh7fffff, 1'b0}, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh800000, 1'b0}, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh800000, 1'b1}, 1'b0, '{24'sd0, 24'sd0, 1'b0}},
    '{'{24'sh123456, 1'b0}, 1'b0, '{24'sd0, 24'sd0, 1'b0}}
  };

  // main sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then directed rows
    tx_idle_pct = 15;
    rx_idle_pct = 82;
    foreach (dir_rows[i]) send_sample(dir_rows[i].stim, dir_rows[i].has_exp, dir_rows[i].wet);
    drain_block();

    // loud room, no damping, mono fold, low quality
    set_all(16'hffff, 16'h0000, 16'h0000, QUAL_LOW);
    for (int i = 0; i < 4; i++) send_sample(dir_rows[i].stim, 1'b0, '0);
    random_run(420);
    drain_block();

    // dead room, full damping, full width, high quality
    tx_idle_pct = 82;
    rx_idle_pct = 15;
    set_all(16'h0000, 16'hffff, 16'hffff, 2'd2);
    random_run(430);
    drain_block();

    // random setting, spare quality code, no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_all(16'($urandom), 16'($urandom), 16'($urandom), 2'd3);
    random_run(430);
    drain_block();

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
